// ===== sv/bcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcsd_pkg: shared types and constants for the case-stego decoder
// Result item layout, status codes, code limits and the code-to-character map.
// ----------------------------------------------------------------------------
package bcsd_pkg;

    localparam int OUTQ_DEPTH = 4;

    localparam logic [5:0] CODE_LIMIT = 6'd53;
    localparam logic [5:0] CODE_END   = 6'd63;
    localparam logic [2:0] FILL_LAST  = 3'd5;

    localparam logic [15:0] CAP_RESET = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic REG_IDX_CAP = 1'b0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_CAP  = 2'd1,
        ST_NO_MARKER = 2'd2,
        ST_BAD_CODE  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_CHAR   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0]  out_char;
        kind_t       kind;
        status_t     status;
        logic [15:0] group_count;
        logic        last_out;
    } res_t;

    typedef struct packed {
        logic       room;
        logic [2:0] level;
    } q_stat_t;

    // Map a valid six-bit code onto its ASCII character
    function automatic logic [7:0] code_char(input logic [5:0] code);
        logic [7:0] ch;
        case (code)
            6'd0:  ch = "A";
            6'd1:  ch = "B";
            6'd2:  ch = "C";
            6'd3:  ch = "D";
            6'd4:  ch = "E";
            6'd5:  ch = "F";
            6'd6:  ch = "G";
            6'd7:  ch = "H";
            6'd8:  ch = "I";
            6'd9:  ch = "J";
            6'd10: ch = "K";
            6'd11: ch = "L";
            6'd12: ch = "M";
            6'd13: ch = "N";
            6'd14: ch = "O";
            6'd15: ch = "P";
            6'd16: ch = "Q";
            6'd17: ch = "R";
            6'd18: ch = "S";
            6'd19: ch = "T";
            6'd20: ch = "U";
            6'd21: ch = "V";
            6'd22: ch = "W";
            6'd23: ch = "X";
            6'd24: ch = "Y";
            6'd25: ch = "Z";
            6'd26: ch = 8'h20;
            6'd27: ch = 8'h21;
            6'd28: ch = 8'h22;
            6'd29: ch = 8'h23;
            6'd30: ch = 8'h24;
            6'd31: ch = 8'h25;
            6'd32: ch = 8'h26;
            6'd33: ch = 8'h27;
            6'd34: ch = 8'h28;
            6'd35: ch = 8'h29;
            6'd36: ch = 8'h2C;
            6'd37: ch = 8'h2D;
            6'd38: ch = 8'h2E;
            6'd39: ch = 8'h2F;
            6'd40: ch = "0";
            6'd41: ch = "1";
            6'd42: ch = "2";
            6'd43: ch = "3";
            6'd44: ch = "4";
            6'd45: ch = "5";
            6'd46: ch = "6";
            6'd47: ch = "7";
            6'd48: ch = "8";
            6'd49: ch = "9";
            6'd50: ch = 8'h3A;
            6'd51: ch = 8'h3B;
            6'd52: ch = 8'h3F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/bacon_case_stego_decoder_top.sv =====
// ----------------------------------------------------------------------------
// bacon_case_stego_decoder_top: case-steganography decoder, six-bit code
// Gathers one bit per cover letter, decodes six-bit groups to characters and
// reports a status item at the end of each message.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries cover text, one byte per item in tdata[7:0], with tlast on
//   the final byte of a message. m_axis carries results: tuser is 0 for a
//   decoded character (tdata[7:0]) and 1 for the status item, which also has
//   status in tdata[9:8], the group count in tdata[25:10] and tlast set.
//   The APB port holds out_capacity at address 0 (reset 65535); write it only
//   while no message is in flight.
//   Every item is decoded in the cycle it is accepted; its results are
//   registered into the result queue and reach m_axis from its head. One
//   item per cycle is taken while the result queue (QDEPTH entries) has room
//   for two more results; the final byte of a message may add both a
//   character and the status item, so the queue takes two results there.
//   When m_axis stalls the queue fills and s_axis tready drops once fewer
//   than two slots remain; nothing is lost.
//   Reset clears the queue and the message state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bacon_case_stego_decoder_top #(
    parameter int QDEPTH = bcsd_pkg::OUTQ_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // cover_char [7:0]
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tlast,
    output logic        s_axis_tready,
    // out_char [7:0], status [9:8], group_count [25:10], zero [31:26]
    output logic [31:0] m_axis_tdata,
    // kind [0]
    output logic        m_axis_tuser,
    output logic        m_axis_tvalid,
    output logic        m_axis_tlast,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] cap_reg;
    logic [5:0]  group_reg;
    logic [5:0]  group_next;
    logic [2:0]  fill_reg;
    logic [2:0]  fill_next;
    logic        marker_reg;
    logic        marker_next;
    logic        bad_reg;
    logic        bad_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;

    logic              in_acc;
    logic              out_acc;
    logic              is_upper;
    logic              is_letter;
    logic              full;
    logic [5:0]        code;
    logic              emit_char;
    bcsd_pkg::status_t status;
    bcsd_pkg::res_t    char_res;
    bcsd_pkg::res_t    stat_res;
    bcsd_pkg::res_t    push0;
    bcsd_pkg::res_t    push1;
    logic [1:0]        push_n;
    bcsd_pkg::res_t    head;
    logic              head_valid;
    bcsd_pkg::q_stat_t q_stat;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bcsd_pkg::REG_IDX_CAP) ? {16'h0000, cap_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bcsd_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == bcsd_pkg::REG_IDX_CAP))
        begin
            cap_reg <= pwdata[15:0];
        end
    end

    // Decode
    always_comb
    begin
        is_upper  = (s_axis_tdata >= 8'h41) && (s_axis_tdata <= 8'h5A);
        is_letter = is_upper || ((s_axis_tdata >= 8'h61) && (s_axis_tdata <= 8'h7A));
        code      = {group_reg[4:0], is_upper};
        full      = is_letter && (fill_reg == bcsd_pkg::FILL_LAST);
        emit_char = full && !marker_reg && (code < bcsd_pkg::CODE_LIMIT)
                    && (count_reg < cap_reg);

        group_next  = group_reg;
        fill_next   = fill_reg;
        marker_next = marker_reg;
        bad_next    = bad_reg;
        count_next  = count_reg;
        if (is_letter)
        begin
            group_next = full ? 6'd0 : code;
            fill_next  = full ? 3'd0 : fill_reg + 3'd1;
        end
        if (full)
        begin
            if ((code >= bcsd_pkg::CODE_LIMIT) && (code != bcsd_pkg::CODE_END))
            begin
                bad_next = 1'b1;
            end
            if (!marker_reg)
            begin
                if (code == bcsd_pkg::CODE_END)
                begin
                    marker_next = 1'b1;
                end
                else if (count_reg != bcsd_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 16'd1;
                end
            end
        end

        if (cap_reg == 16'd0)
        begin
            status = bcsd_pkg::ST_ZERO_CAP;
        end
        else if (!marker_next)
        begin
            status = bcsd_pkg::ST_NO_MARKER;
        end
        else if (bad_next)
        begin
            status = bcsd_pkg::ST_BAD_CODE;
        end
        else
        begin
            status = bcsd_pkg::ST_OK;
        end

        char_res.out_char    = bcsd_pkg::code_char(code);
        char_res.kind        = bcsd_pkg::KIND_CHAR;
        char_res.status      = bcsd_pkg::ST_OK;
        char_res.group_count = 16'd0;
        char_res.last_out    = 1'b0;

        stat_res.out_char    = 8'h00;
        stat_res.kind        = bcsd_pkg::KIND_STATUS;
        stat_res.status      = status;
        stat_res.group_count = count_next;
        stat_res.last_out    = 1'b1;

        // character first, status behind it
        push0  = emit_char ? char_res : stat_res;
        push1  = stat_res;
        push_n = in_acc ? (2'(emit_char) + 2'(s_axis_tlast)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg  <= '0;
            fill_reg   <= '0;
            marker_reg <= 1'b0;
            bad_reg    <= 1'b0;
            count_reg  <= '0;
        end
        else if (in_acc)
        begin
            if (s_axis_tlast)
            begin
                // drop message state, keep capacity
                group_reg  <= '0;
                fill_reg   <= '0;
                marker_reg <= 1'b0;
                bad_reg    <= 1'b0;
                count_reg  <= '0;
            end
            else
            begin
                group_reg  <= group_next;
                fill_reg   <= fill_next;
                marker_reg <= marker_next;
                bad_reg    <= bad_next;
                count_reg  <= count_next;
            end
        end
    end

    bcsd_outq #(
        .QDEPTH(QDEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push0     (push0),
        .push1     (push1),
        .pop       (out_acc),
        .head      (head),
        .head_valid(head_valid),
        .stat      (q_stat)
    );

    assign s_axis_tready = q_stat.room;
    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {6'd0, head.group_count, head.status, head.out_char};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last_out;

    // Checks
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= bcsd_pkg::FILL_LAST)
        else $error("bit fill out of range");

    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (32'(q_stat.level) <= QDEPTH - 2))
        else $error("item accepted without room for two results");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tlast) |=> (fill_reg == 3'd0 && count_reg == 16'd0 && !marker_reg))
        else $error("message state not cleared after final byte");

    a_status_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
        else $error("status item and end mark disagree");

endmodule

// ===== sv/bcsd_outq.sv =====
// ----------------------------------------------------------------------------
// bcsd_outq: result queue
// Small shift queue that takes up to two result items per cycle and hands out
// one per cycle, when popped, from its head register.
// ----------------------------------------------------------------------------
module bcsd_outq #(
    parameter int QDEPTH = bcsd_pkg::OUTQ_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_n,
    input  bcsd_pkg::res_t    push0,
    input  bcsd_pkg::res_t    push1,
    input  logic              pop,
    output bcsd_pkg::res_t    head,
    output logic              head_valid,
    output bcsd_pkg::q_stat_t stat
);

    localparam int LVL_W = $clog2(QDEPTH + 1);

    bcsd_pkg::res_t   ent_reg   [QDEPTH];
    bcsd_pkg::res_t   ent_next  [QDEPTH];
    bcsd_pkg::res_t   shifted   [QDEPTH];
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic [LVL_W-1:0] level_after;

    always_comb
    begin
        level_after = level_reg - LVL_W'(pop);
        level_next  = level_after + LVL_W'(push_n);
        for (int i = 0; i < QDEPTH - 1; i++)
        begin
            shifted[i] = ent_reg[i + 1];
        end
        shifted[QDEPTH-1] = ent_reg[QDEPTH-1];
        for (int i = 0; i < QDEPTH; i++)
        begin
            ent_next[i] = pop ? shifted[i] : ent_reg[i];
            // first pushed item lands right behind the survivors
            if ((push_n != 2'd0) && (LVL_W'(i) == level_after))
            begin
                ent_next[i] = push0;
            end
            if ((push_n == 2'd2) && (LVL_W'(i) == level_after + LVL_W'(1)))
            begin
                ent_next[i] = push1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
    end

    assign head       = ent_reg[0];
    assign head_valid = (level_reg != '0);
    assign stat.room  = (level_reg <= LVL_W'(QDEPTH - 2));
    assign stat.level = 3'(level_reg);

endmodule
